FILE: sv/bba_pkg.sv
// Shared types, constants and a helper function for the bitmap block allocator.
package bba_pkg;

  localparam int NUM_BLOCKS = 32768;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int LIMIT_W    = BLK_W + 1;
  localparam int WORD_W     = 32;
  localparam int WBIT_W     = $clog2(WORD_W);
  localparam int WORDS      = NUM_BLOCKS / WORD_W;
  localparam int WIDX_W     = $clog2(WORDS);
  localparam int GROUPS     = WORDS / WORD_W;
  localparam int GRP_W      = WIDX_W - WBIT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [BLK_W-1:0]   FIRST_RESET = BLK_W'(16);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(24992);

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_USABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_USABLE_LIMIT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FORMAT = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef struct packed {
    op_t              operation;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] allocated_block;
  } rsp_t;

  typedef struct packed {
    logic [BLK_W-1:0]   first_usable_block;
    logic [LIMIT_W-1:0] usable_block_limit;
  } cfg_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [WIDX_W-1:0] addr;
    word_t             wdata;
  } dmem_req_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [GRP_W-1:0] addr;
    word_t            wdata;
  } smem_req_t;

  typedef struct packed {
    logic              found;
    logic [WBIT_W-1:0] idx;
  } ffs_t;

  // lowest set bit
  function automatic ffs_t ffs(input word_t v);
    ffs_t r;
    r.found = |v;
    r.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.idx = WBIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/bba_ram.sv
// Single-port synchronous RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd,
  input  logic              wr,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: sv/bba_seq.sv
// Request sequencer: summary-guided first-fit scan, free, and format sweep.
module bba_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bba_pkg::req_t      in_request,
  input  bba_pkg::cfg_t      cfg,
  output logic               busy,
  output logic               out_valid,
  output bba_pkg::rsp_t      out_result,
  output bba_pkg::dmem_req_t dmem_req,
  input  bba_pkg::word_t     dmem_rdata,
  output bba_pkg::smem_req_t smem_req,
  input  bba_pkg::word_t     smem_rdata
);

  localparam bba_pkg::word_t ALL_ONES = '1;
  localparam bba_pkg::word_t WORD_ONE = bba_pkg::WORD_W'(1);
  localparam logic [bba_pkg::GROUPS-1:0] GRP_ONES = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_TOP, S_SUM, S_DATA, S_FSUM, S_FDATA, S_FMT_D, S_FMT_S
  } state_t;

  state_t                            state_r, state_nxt;
  logic [bba_pkg::GROUPS-1:0]        top_r, top_nxt;
  logic [bba_pkg::WIDX_W:0]          scan_r, scan_nxt;
  logic [bba_pkg::GRP_W-1:0]         grp_r, grp_nxt;
  logic [bba_pkg::WIDX_W-1:0]        word_r, word_nxt;
  bba_pkg::word_t                    sum_r, sum_nxt;
  logic [bba_pkg::BLK_W-1:0]         blk_r, blk_nxt;
  logic                              out_valid_r, out_valid_nxt;
  bba_pkg::rsp_t                     out_result_r, out_result_nxt;

  logic [bba_pkg::LIMIT_W-1:0] hi_clip;
  logic                        range_empty;
  logic [bba_pkg::BLK_W-1:0]   last_blk;
  logic [bba_pkg::WIDX_W-1:0]  lo_word, last_word;

  logic [bba_pkg::GROUPS-1:0]  top_masked;
  bba_pkg::ffs_t               grp_hit, sum_hit, data_hit;
  logic [bba_pkg::GRP_W-1:0]   grp_found;
  logic [bba_pkg::WBIT_W-1:0]  sum_lo;
  bba_pkg::word_t              sum_masked, data_masked, data_clr, sum_clr;
  logic [bba_pkg::WIDX_W-1:0]  cand_word;

  logic [bba_pkg::GRP_W-1:0]   f_grp;
  logic [bba_pkg::WBIT_W-1:0]  f_sub, f_bit;
  bba_pkg::word_t              f_sum;
  bba_pkg::word_t              fmt_sum;

  function automatic bba_pkg::word_t range_mask(
    input logic [bba_pkg::WIDX_W-1:0] d,
    input logic [bba_pkg::BLK_W-1:0]  lo,
    input logic [bba_pkg::BLK_W-1:0]  last
  );
    bba_pkg::word_t lo_m, hi_m;
    lo_m = (d == lo[bba_pkg::BLK_W-1:bba_pkg::WBIT_W]) ?
           (ALL_ONES << lo[bba_pkg::WBIT_W-1:0]) : ALL_ONES;
    hi_m = (d == last[bba_pkg::BLK_W-1:bba_pkg::WBIT_W]) ?
           (ALL_ONES >> (bba_pkg::WBIT_W'(bba_pkg::WORD_W - 1) -
                         last[bba_pkg::WBIT_W-1:0])) : ALL_ONES;
    return lo_m & hi_m;
  endfunction

  assign hi_clip = (cfg.usable_block_limit > bba_pkg::LIMIT_W'(bba_pkg::NUM_BLOCKS)) ?
                   bba_pkg::LIMIT_W'(bba_pkg::NUM_BLOCKS) : cfg.usable_block_limit;
  assign range_empty = {1'b0, cfg.first_usable_block} >= hi_clip;
  assign last_blk    = bba_pkg::BLK_W'(hi_clip - bba_pkg::LIMIT_W'(1));
  assign lo_word     = cfg.first_usable_block[bba_pkg::BLK_W-1:bba_pkg::WBIT_W];
  assign last_word   = last_blk[bba_pkg::BLK_W-1:bba_pkg::WBIT_W];

  // allocate scan
  assign top_masked = top_r & (GRP_ONES << scan_r[bba_pkg::WIDX_W-1:bba_pkg::WBIT_W]);
  assign grp_hit    = bba_pkg::ffs(bba_pkg::WORD_W'(top_masked));
  assign grp_found  = bba_pkg::GRP_W'(grp_hit.idx);
  assign sum_lo     = (grp_r == scan_r[bba_pkg::WIDX_W-1:bba_pkg::WBIT_W]) ?
                      scan_r[bba_pkg::WBIT_W-1:0] : '0;
  assign sum_masked = smem_rdata & (ALL_ONES << sum_lo);
  assign sum_hit    = bba_pkg::ffs(sum_masked);
  assign cand_word  = {grp_r, sum_hit.idx};
  assign data_masked = dmem_rdata & range_mask(word_r, cfg.first_usable_block, last_blk);
  assign data_hit   = bba_pkg::ffs(data_masked);
  assign data_clr   = dmem_rdata & ~(WORD_ONE << data_hit.idx);
  assign sum_clr    = sum_r & ~(WORD_ONE << word_r[bba_pkg::WBIT_W-1:0]);

  // free
  assign f_grp = blk_r[bba_pkg::BLK_W-1:bba_pkg::BLK_W-bba_pkg::GRP_W];
  assign f_sub = blk_r[bba_pkg::BLK_W-bba_pkg::GRP_W-1:bba_pkg::WBIT_W];
  assign f_bit = blk_r[bba_pkg::WBIT_W-1:0];
  assign f_sum = top_r[f_grp] ? smem_rdata : '0;

  // format summary word for grp_r
  always_comb begin
    logic [bba_pkg::WIDX_W-1:0] wi;
    for (int j = 0; j < bba_pkg::WORD_W; j++) begin
      wi = {grp_r, bba_pkg::WBIT_W'(j)};
      fmt_sum[j] = !range_empty && (wi >= lo_word) && (wi <= last_word);
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    scan_nxt       = scan_r;
    grp_nxt        = grp_r;
    word_nxt       = word_r;
    sum_nxt        = sum_r;
    blk_nxt        = blk_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    dmem_req       = '0;
    smem_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          blk_nxt = in_request.block_number;
          case (in_request.operation)
            bba_pkg::OP_ALLOC: begin
              if (range_empty) begin
                out_valid_nxt  = 1'b1;
                out_result_nxt = '{bba_pkg::ST_NO_FREE, '0};
              end else begin
                scan_nxt  = {1'b0, lo_word};
                state_nxt = S_TOP;
              end
            end
            bba_pkg::OP_FREE: begin
              if ((in_request.block_number < cfg.first_usable_block) ||
                  ({1'b0, in_request.block_number} >= hi_clip)) begin
                out_valid_nxt  = 1'b1;
                out_result_nxt = '{bba_pkg::ST_RANGE, '0};
              end else begin
                smem_req.rd   = 1'b1;
                smem_req.addr = in_request.block_number[bba_pkg::BLK_W-1:
                                                        bba_pkg::BLK_W-bba_pkg::GRP_W];
                state_nxt     = S_FSUM;
              end
            end
            bba_pkg::OP_FORMAT: begin
              grp_nxt  = '0;
              word_nxt = lo_word;
              state_nxt = range_empty ? S_FMT_S : S_FMT_D;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = '{bba_pkg::ST_OK, '0};
            end
          endcase
        end
      end

      S_TOP: begin
        if (scan_r[bba_pkg::WIDX_W] || !grp_hit.found ||
            (grp_found > last_word[bba_pkg::WIDX_W-1:bba_pkg::WBIT_W])) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = '{bba_pkg::ST_NO_FREE, '0};
          state_nxt      = S_IDLE;
        end else begin
          smem_req.rd   = 1'b1;
          smem_req.addr = grp_found;
          grp_nxt       = grp_found;
          state_nxt     = S_SUM;
        end
      end

      S_SUM: begin
        sum_nxt = smem_rdata;
        if (!sum_hit.found) begin
          scan_nxt  = {({1'b0, grp_r} + 1'b1), bba_pkg::WBIT_W'(0)};
          state_nxt = S_TOP;
        end else if (cand_word > last_word) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = '{bba_pkg::ST_NO_FREE, '0};
          state_nxt      = S_IDLE;
        end else begin
          dmem_req.rd   = 1'b1;
          dmem_req.addr = cand_word;
          word_nxt      = cand_word;
          state_nxt     = S_DATA;
        end
      end

      S_DATA: begin
        if (!data_hit.found) begin
          scan_nxt  = {1'b0, word_r} + 1'b1;
          state_nxt = S_TOP;
        end else begin
          dmem_req.wr    = 1'b1;
          dmem_req.addr  = word_r;
          dmem_req.wdata = data_clr;
          if (data_clr == '0) begin
            smem_req.wr    = 1'b1;
            smem_req.addr  = grp_r;
            smem_req.wdata = sum_clr;
            if (sum_clr == '0) begin
              top_nxt[grp_r] = 1'b0;
            end
          end
          out_valid_nxt  = 1'b1;
          out_result_nxt = '{bba_pkg::ST_OK, {word_r, data_hit.idx}};
          state_nxt      = S_IDLE;
        end
      end

      S_FSUM: begin
        sum_nxt = f_sum;
        if (f_sum[f_sub]) begin
          dmem_req.rd   = 1'b1;
          dmem_req.addr = blk_r[bba_pkg::BLK_W-1:bba_pkg::WBIT_W];
          state_nxt     = S_FDATA;
        end else begin
          // word holds no free block yet, its stored contents are stale
          dmem_req.wr    = 1'b1;
          dmem_req.addr  = blk_r[bba_pkg::BLK_W-1:bba_pkg::WBIT_W];
          dmem_req.wdata = WORD_ONE << f_bit;
          smem_req.wr    = 1'b1;
          smem_req.addr  = f_grp;
          smem_req.wdata = f_sum | (WORD_ONE << f_sub);
          top_nxt[f_grp] = 1'b1;
          out_valid_nxt  = 1'b1;
          out_result_nxt = '{bba_pkg::ST_OK, '0};
          state_nxt      = S_IDLE;
        end
      end

      S_FDATA: begin
        out_valid_nxt = 1'b1;
        if (dmem_rdata[f_bit]) begin
          out_result_nxt = '{bba_pkg::ST_ALREADY_FREE, '0};
        end else begin
          dmem_req.wr    = 1'b1;
          dmem_req.addr  = blk_r[bba_pkg::BLK_W-1:bba_pkg::WBIT_W];
          dmem_req.wdata = dmem_rdata | (WORD_ONE << f_bit);
          out_result_nxt = '{bba_pkg::ST_OK, '0};
        end
        state_nxt = S_IDLE;
      end

      S_FMT_D: begin
        dmem_req.wr    = 1'b1;
        dmem_req.addr  = word_r;
        dmem_req.wdata = range_mask(word_r, cfg.first_usable_block, last_blk);
        if (word_r == last_word) begin
          grp_nxt   = '0;
          state_nxt = S_FMT_S;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end

      S_FMT_S: begin
        smem_req.wr    = 1'b1;
        smem_req.addr  = grp_r;
        smem_req.wdata = fmt_sum;
        top_nxt[grp_r] = |fmt_sum;
        if (grp_r == bba_pkg::GRP_W'(bba_pkg::GROUPS - 1)) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = '{bba_pkg::ST_OK, '0};
          state_nxt      = S_IDLE;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r       <= scan_nxt;
    grp_r        <= grp_nxt;
    word_r       <= word_nxt;
    sum_r        <= sum_nxt;
    blk_r        <= blk_nxt;
    out_result_r <= out_result_nxt;
  end

endmodule

FILE: sv/bitmap_block_allocator.sv
// Top level of the free-block bitmap allocator: config registers, sequencer, map memories.
//
//   channel  handshake               payload
//   in       start & !busy           in_request  (operation, block_number)
//   out      out_valid (1 cycle)     out_result  (status, allocated_block)
//   cfg      cfg_valid & cfg_ready   cfg_index, cfg_data
//
// One request at a time; its result appears the cycle after the last work cycle.
// Allocate: an empty range needs no memory read, else the result follows alternating reads of the
//   group summary memory and the bitmap word memory (a boundary word can force another pass).
// Free: out of range needs no memory read; else a summary read, then a word read if marked free.
// Format: writes each 32-block word in the usable range, then all 32 summary words, then result.
// Reset needs no clearing pass: the group flags clear at once and stale words are
//   never trusted. Results cannot be stalled; the next request may start as one shows.
module bitmap_block_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  bba_pkg::req_t                    in_request,
  output logic                             out_valid,
  output bba_pkg::rsp_t                    out_result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bba_pkg::cfg_t      cfg_r, cfg_nxt;
  bba_pkg::dmem_req_t dmem_req;
  bba_pkg::smem_req_t smem_req;
  bba_pkg::word_t     dmem_rdata, smem_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        bba_pkg::REG_FIRST_USABLE:
          cfg_nxt.first_usable_block = cfg_data[bba_pkg::BLK_W-1:0];
        bba_pkg::REG_USABLE_LIMIT:
          cfg_nxt.usable_block_limit = cfg_data[bba_pkg::LIMIT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{bba_pkg::FIRST_RESET, bba_pkg::LIMIT_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bba_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_request (in_request),
    .cfg        (cfg_r),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_result (out_result),
    .dmem_req   (dmem_req),
    .dmem_rdata (dmem_rdata),
    .smem_req   (smem_req),
    .smem_rdata (smem_rdata)
  );

  bba_ram #(.WIDTH(bba_pkg::WORD_W), .DEPTH(bba_pkg::WORDS)) u_word_ram (
    .clk   (clk),
    .rd    (dmem_req.rd),
    .wr    (dmem_req.wr),
    .addr  (dmem_req.addr),
    .wdata (dmem_req.wdata),
    .rdata (dmem_rdata)
  );

  bba_ram #(.WIDTH(bba_pkg::WORD_W), .DEPTH(bba_pkg::GROUPS)) u_sum_ram (
    .clk   (clk),
    .rd    (smem_req.rd),
    .wr    (smem_req.wr),
    .addr  (smem_req.addr),
    .wdata (smem_req.wdata),
    .rdata (smem_rdata)
  );

endmodule

FILE: sv/bba_checker.sv
// Port-level checks for the bitmap block allocator, bound to the top level.
module bba_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input bba_pkg::rsp_t out_result
);

  a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start && !busy)))
    else $error("result without a pending request");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while a result is shown");

  a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither worked on nor answered");

  a_block_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result.status != bba_pkg::ST_OK)) |->
      (out_result.allocated_block == '0))
    else $error("nonzero block on a failed request");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);

FILE: bench/bitmap_block_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the first-fit free-block bitmap allocator: directed table, then random phases.
module bitmap_block_allocator_tb;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 11;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_REQUESTS = 48;

  typedef struct packed {
    logic                           is_write;
    logic [bba_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [bba_pkg::CFG_DATA_W-1:0] data;
    bba_pkg::req_t                  req;
    logic                           typed;
    bba_pkg::rsp_t                  rsp;
  } step_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  bba_pkg::req_t                  in_request = '0;
  logic                           out_valid;
  bba_pkg::rsp_t                  out_result;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bit                             free_bit [bba_pkg::NUM_BLOCKS];
  logic [bba_pkg::BLK_W-1:0]      first_blk = bba_pkg::FIRST_RESET;
  logic [bba_pkg::LIMIT_W-1:0]    limit_blk = bba_pkg::LIMIT_RESET;

  bba_pkg::rsp_t pending_results [$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   requests_sent = 0;
  int   reg_writes = 0;
  int   blocks_given = 0;
  int   none_free = 0;
  int   out_of_range = 0;
  int   double_frees = 0;

  bitmap_block_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_request (in_request),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic bba_pkg::rsp_t allocator_result(bba_pkg::req_t r);
    bba_pkg::rsp_t res;
    int   lo;
    int   hi;
    int   blk;
    lo = int'(first_blk);
    hi = (int'(limit_blk) > bba_pkg::NUM_BLOCKS) ? bba_pkg::NUM_BLOCKS : int'(limit_blk);
    blk = int'(r.block_number);
    res.status = bba_pkg::ST_OK;
    res.allocated_block = '0;
    case (r.operation)
      bba_pkg::OP_ALLOC: begin
        res.status = bba_pkg::ST_NO_FREE;
        for (int b = lo; b < hi; b++) begin
          if (free_bit[b]) begin
            free_bit[b] = 1'b0;
            res.status = bba_pkg::ST_OK;
            res.allocated_block = bba_pkg::BLK_W'(b);
            blocks_given++;
            break;
          end
        end
      end
      bba_pkg::OP_FREE: begin
        if (blk < lo || blk >= hi) begin
          res.status = bba_pkg::ST_RANGE;
        end else if (free_bit[blk]) begin
          res.status = bba_pkg::ST_ALREADY_FREE;
        end else begin
          free_bit[blk] = 1'b1;
        end
      end
      bba_pkg::OP_FORMAT: begin
        for (int b = 0; b < bba_pkg::NUM_BLOCKS; b++) begin
          free_bit[b] = (b >= lo && b < hi);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic step_t req_step(bba_pkg::op_t op, int blk);
    step_t s;
    s = '0;
    s.req.operation = op;
    s.req.block_number = bba_pkg::BLK_W'(blk);
    return s;
  endfunction

  function automatic step_t checked_step(bba_pkg::op_t op, int blk, bba_pkg::status_t st,
                                         int given);
    step_t s;
    s = req_step(op, blk);
    s.typed = 1'b1;
    s.rsp.status = st;
    s.rsp.allocated_block = bba_pkg::BLK_W'(given);
    return s;
  endfunction

  function automatic step_t reg_step(logic [bba_pkg::CFG_IDX_W-1:0] idx, int data);
    step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.data = bba_pkg::CFG_DATA_W'(data);
    return s;
  endfunction

  task automatic send_request(bba_pkg::req_t r, logic typed, bba_pkg::rsp_t typed_rsp);
    bba_pkg::rsp_t predicted;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(10, 30)) :
                                          int'($urandom_range(0, 6));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 40));
    end
    burst_left--;
    in_request <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = allocator_result(r);
    pending_results.push_back(typed ? typed_rsp : predicted);
    requests_sent++;
  endtask

  // registers change only with the block idle
  task automatic write_register(logic [bba_pkg::CFG_IDX_W-1:0] idx,
                                logic [bba_pkg::CFG_DATA_W-1:0] data);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == bba_pkg::REG_FIRST_USABLE) begin
      first_blk = data[bba_pkg::BLK_W-1:0];
    end else begin
      limit_blk = data;
    end
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    bba_pkg::rsp_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with no request pending: status %0d block %0d",
                   out_result.status, out_result.allocated_block);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_result.status !== want.status ||
            out_result.allocated_block !== want.allocated_block) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected status %0d block %0d, got status %0d block %0d",
                     want.status, want.allocated_block,
                     out_result.status, out_result.allocated_block);
          end
        end
        case (want.status)
          bba_pkg::ST_NO_FREE:      none_free++;
          bba_pkg::ST_RANGE:        out_of_range++;
          bba_pkg::ST_ALREADY_FREE: double_frees++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    step_t         script [$];
    bba_pkg::req_t r;
    int            lo;
    int            lim;
    int            pick;
    script = '{
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_NO_FREE, 0),
      checked_step(bba_pkg::OP_FREE, 15, bba_pkg::ST_RANGE, 0),
      checked_step(bba_pkg::OP_FREE, 24992, bba_pkg::ST_RANGE, 0),
      checked_step(bba_pkg::OP_FREE, 16, bba_pkg::ST_OK, 0),
      checked_step(bba_pkg::OP_FREE, 16, bba_pkg::ST_ALREADY_FREE, 0),
      checked_step(bba_pkg::OP_ALLOC, 32767, bba_pkg::ST_OK, 16),
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_NO_FREE, 0),
      checked_step(bba_pkg::OP_NOP, 32767, bba_pkg::ST_OK, 0),
      checked_step(bba_pkg::OP_FORMAT, 0, bba_pkg::ST_OK, 0),
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_OK, 16),
      req_step(bba_pkg::OP_ALLOC, 0),
      checked_step(bba_pkg::OP_FREE, 24991, bba_pkg::ST_ALREADY_FREE, 0),
      req_step(bba_pkg::OP_FREE, 16),
      // limit above the block count gets clipped
      reg_step(bba_pkg::REG_FIRST_USABLE, 0),
      reg_step(bba_pkg::REG_USABLE_LIMIT, 16'hFFFF),
      checked_step(bba_pkg::OP_FORMAT, 0, bba_pkg::ST_OK, 0),
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_OK, 0),
      checked_step(bba_pkg::OP_FREE, 32767, bba_pkg::ST_ALREADY_FREE, 0),
      checked_step(bba_pkg::OP_FREE, 0, bba_pkg::ST_OK, 0),
      // stale free bits below the range must never be handed out
      reg_step(bba_pkg::REG_FIRST_USABLE, 16'hFFFF),
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_OK, 32767),
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_NO_FREE, 0),
      checked_step(bba_pkg::OP_FREE, 32766, bba_pkg::ST_RANGE, 0),
      // empty range
      reg_step(bba_pkg::REG_FIRST_USABLE, 500),
      reg_step(bba_pkg::REG_USABLE_LIMIT, 500),
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_NO_FREE, 0),
      checked_step(bba_pkg::OP_FREE, 500, bba_pkg::ST_RANGE, 0),
      checked_step(bba_pkg::OP_FORMAT, 0, bba_pkg::ST_OK, 0),
      reg_step(bba_pkg::REG_FIRST_USABLE, 0),
      reg_step(bba_pkg::REG_USABLE_LIMIT, 1),
      checked_step(bba_pkg::OP_FREE, 0, bba_pkg::ST_OK, 0),
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_OK, 0),
      checked_step(bba_pkg::OP_ALLOC, 0, bba_pkg::ST_NO_FREE, 0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        write_register(script[i].reg_idx, script[i].data);
      end else begin
        send_request(script[i].req, script[i].typed, script[i].rsp);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0: begin
          lo = int'($urandom_range(0, 64));
          lim = int'($urandom_range(32768, 65535));
        end
        1: begin
          lo = int'($urandom_range(1, 32767));
          lim = int'($urandom_range(1, lo));
        end
        2: begin
          lo = int'($urandom_range(0, 30000));
          lim = lo + int'($urandom_range(64, 2048));
        end
        3: begin
          lo = int'($urandom_range(32700, 32767));
          lim = int'($urandom_range(32768, 65535));
        end
        default: begin
          lo = int'($urandom_range(0, 32760));
          lim = lo + int'($urandom_range(1, 40));
        end
      endcase
      write_register(bba_pkg::REG_FIRST_USABLE,
                     {1'($urandom_range(0, 1)), bba_pkg::BLK_W'(lo)});
      write_register(bba_pkg::REG_USABLE_LIMIT, bba_pkg::LIMIT_W'(lim));
      if (lim > bba_pkg::NUM_BLOCKS) lim = bba_pkg::NUM_BLOCKS;

      if ($urandom_range(0, 3) != 0) begin
        r.operation = bba_pkg::OP_FORMAT;
        r.block_number = bba_pkg::BLK_W'($urandom_range(0, bba_pkg::NUM_BLOCKS - 1));
        send_request(r, 1'b0, '0);
      end

      repeat (PHASE_REQUESTS) begin
        pick = int'($urandom_range(0, 99));
        r.block_number = bba_pkg::BLK_W'($urandom_range(0, bba_pkg::NUM_BLOCKS - 1));
        if (pick < 45) begin
          r.operation = bba_pkg::OP_ALLOC;
        end else if (pick < 85) begin
          r.operation = bba_pkg::OP_FREE;
          if (lim > lo && $urandom_range(0, 3) != 0) begin
            r.block_number = bba_pkg::BLK_W'(lo + int'($urandom_range(0, lim - lo - 1)));
          end
        end else if (pick < 90) begin
          r.operation = bba_pkg::OP_FORMAT;
        end else begin
          r.operation = bba_pkg::OP_NOP;
        end
        send_request(r, 1'b0, '0);
      end
    end

    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests across %0d register writes, including clipped and empty ranges",
             requests_sent, reg_writes);
    $display("%0d blocks allocated, %0d with none free, %0d out of range, %0d double frees",
             blocks_given, none_free, out_of_range, double_frees);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_seq.sv
sv/bitmap_block_allocator.sv
sv/bba_checker.sv
bench/bitmap_block_allocator_tb.sv
